// File: rtl/packet_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Packet frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAME_PARSER_MACROS_SVH
`define PACKET_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define PFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PFP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Types and constants shared by the packet frame parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfp_pkg;

	localparam int HDR_LEN = 2 + 1 + 1 + 8 + 8 + 1 + 2;
	localparam int BC_W    = 17;

	localparam logic [BC_W-1:0] COUNT_MAX = '1;
	localparam logic [BC_W-1:0] HDR_LEN_W = BC_W'(HDR_LEN);

	// Header byte positions.
	localparam logic [4:0] IDX_MAGIC_HI  = 5'd0;
	localparam logic [4:0] IDX_MAGIC_LO  = 5'd1;
	localparam logic [4:0] IDX_VERSION   = 5'd2;
	localparam logic [4:0] IDX_FLAGS     = 5'd3;
	localparam logic [4:0] IDX_SEQ_FIRST = 5'd12;
	localparam logic [4:0] IDX_COUNT     = 5'd20;
	localparam logic [4:0] IDX_HDR_LAST  = 5'(HDR_LEN - 1);

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_MARKER  = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_VERSION  = 3'd3,
		ST_LENGTH   = 3'd4,
		ST_OVERRUN  = 3'd5,
		ST_TRAILING = 3'd6
	} status_t;

	// One queue entry: the work that one input byte leaves for the back end.
	typedef struct packed {
		logic        has_frame;
		kind_t       frame_kind;
		logic [7:0]  data_byte;
		logic [7:0]  frame_type;
		logic [7:0]  frame_index;
		logic        frame_end;
		logic        has_verdict;
		status_t     status;
		logic [7:0]  hdr_flags;
		logic [63:0] hdr_session;
		logic [63:0] hdr_sequence;
		logic [7:0]  hdr_frames;
	} entry_t;

endpackage

// File: rtl/pfp_front.sv
// ----------------------------------------------------------------------------
// pfp_front
// Accepts packet bytes, tracks header and frame state and queues one entry
// per byte that gives a frame item, a verdict or both.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_frame_parser_macros.svh"

module pfp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     expected_magic,
	input  logic [7:0]      expected_version,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic            q_full,
	output logic            q_push,
	output pfp_pkg::entry_t q_data
);
	import pfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_TYPE   = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_DATA   = 3'd4,
		PH_DONE   = 3'd5,
		PH_SKIP   = 3'd6
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BC_W-1:0]   byte_count_q, byte_count_d;
	logic [7:0]        flags_q, flags_d;
	logic [63:0]       session_q, session_d;
	logic [63:0]       sequence_q, sequence_d;
	logic [7:0]        count_q, count_d;
	logic [15:0]       plen_q, plen_d;
	logic [8:0]        frames_done_q, frames_done_d;
	logic [7:0]        cur_type_q, cur_type_d;
	logic [15:0]       remaining_q, remaining_d;
	status_t           err_q, err_d;
	logic              accept;
	logic [4:0]        idx;
	logic [8:0]        fd_inc;
	logic [BC_W-1:0]   expect_len;
	status_t           verdict;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign idx      = byte_count_q[4:0];
	assign fd_inc   = frames_done_q + 9'd1;

	always_comb begin
		phase_d       = phase_q;
		flags_d       = flags_q;
		session_d     = session_q;
		sequence_d    = sequence_q;
		count_d       = count_q;
		plen_d        = plen_q;
		frames_done_d = frames_done_q;
		cur_type_d    = cur_type_q;
		remaining_d   = remaining_q;
		err_d         = err_q;
		q_data        = '0;

		unique case (phase_q)
			PH_HEADER: begin
				if (idx == IDX_MAGIC_HI) begin
					if (in_byte != expected_magic[15:8] && err_q == ST_OK) begin
						err_d = ST_MAGIC;
					end
				end else if (idx == IDX_MAGIC_LO) begin
					if (in_byte != expected_magic[7:0] && err_q == ST_OK) begin
						err_d = ST_MAGIC;
					end
				end else if (idx == IDX_VERSION) begin
					if (in_byte != expected_version && err_q == ST_OK) begin
						err_d = ST_VERSION;
					end
				end else if (idx == IDX_FLAGS) begin
					flags_d = in_byte;
				end else if (idx < IDX_SEQ_FIRST) begin
					session_d = {session_q[55:0], in_byte};
				end else if (idx < IDX_COUNT) begin
					sequence_d = {sequence_q[55:0], in_byte};
				end else if (idx == IDX_COUNT) begin
					count_d = in_byte;
				end else begin
					plen_d = {plen_q[7:0], in_byte};
				end
				if (idx == IDX_HDR_LAST) begin
					if (err_d != ST_OK) begin
						phase_d = PH_SKIP;
					end else if (count_d == 8'd0) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				cur_type_d = in_byte;
				phase_d    = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				remaining_d = {in_byte, 8'd0};
				phase_d     = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				remaining_d = {remaining_q[15:8], in_byte};
				if (remaining_d == 16'd0) begin
					q_data.has_frame  = 1'b1;
					q_data.frame_kind = KIND_MARKER;
					frames_done_d     = fd_inc;
					phase_d = (fd_inc >= {1'b0, count_q}) ? PH_DONE : PH_TYPE;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				remaining_d       = remaining_q - 16'd1;
				q_data.has_frame  = 1'b1;
				q_data.frame_kind = KIND_DATA;
				q_data.data_byte  = in_byte;
				q_data.frame_end  = (remaining_d == 16'd0);
				if (remaining_d == 16'd0) begin
					frames_done_d = fd_inc;
					phase_d = (fd_inc >= {1'b0, count_q}) ? PH_DONE : PH_TYPE;
				end
			end
			PH_DONE: begin
				if (err_q == ST_OK) begin
					err_d = ST_TRAILING;
				end
			end
			default: begin
			end
		endcase

		q_data.frame_type  = q_data.has_frame ? cur_type_d : 8'd0;
		q_data.frame_index = q_data.has_frame ? frames_done_q[7:0] : 8'd0;

		byte_count_d = (byte_count_q != COUNT_MAX) ? byte_count_q + 1'b1 : byte_count_q;
		expect_len   = HDR_LEN_W + {1'b0, plen_d};

		// Verdict checks in priority order: short header, magic or version, length, overrun, then any trailing-byte error.
		if (byte_count_d < HDR_LEN_W) begin
			verdict = ST_SHORT;
		end else if (err_d == ST_MAGIC || err_d == ST_VERSION) begin
			verdict = err_d;
		end else if (byte_count_d != expect_len) begin
			verdict = ST_LENGTH;
		end else if (phase_d != PH_DONE) begin
			verdict = ST_OVERRUN;
		end else begin
			verdict = err_d;
		end

		q_data.has_verdict = in_last;
		q_data.status      = in_last ? verdict : ST_OK;
		if (in_last && verdict != ST_SHORT) begin
			q_data.hdr_flags    = flags_d;
			q_data.hdr_session  = session_d;
			q_data.hdr_sequence = sequence_d;
			q_data.hdr_frames   = count_d;
		end
	end

	assign q_push = accept && (q_data.has_frame || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			byte_count_q  <= '0;
			flags_q       <= '0;
			session_q     <= '0;
			sequence_q    <= '0;
			count_q       <= '0;
			plen_q        <= '0;
			frames_done_q <= '0;
			cur_type_q    <= '0;
			remaining_q   <= '0;
			err_q         <= ST_OK;
		end else if (accept) begin
			if (in_last) begin
				phase_q       <= PH_HEADER;
				byte_count_q  <= '0;
				flags_q       <= '0;
				session_q     <= '0;
				sequence_q    <= '0;
				count_q       <= '0;
				plen_q        <= '0;
				frames_done_q <= '0;
				cur_type_q    <= '0;
				remaining_q   <= '0;
				err_q         <= ST_OK;
			end else begin
				phase_q       <= phase_d;
				byte_count_q  <= byte_count_d;
				flags_q       <= flags_d;
				session_q     <= session_d;
				sequence_q    <= sequence_d;
				count_q       <= count_d;
				plen_q        <= plen_d;
				frames_done_q <= frames_done_d;
				cur_type_q    <= cur_type_d;
				remaining_q   <= remaining_d;
				err_q         <= err_d;
			end
		end
	end

	// Frame parsing only starts once the whole header has been counted.
	`PFP_ASSERT_IMP(a_front_hdr_done, phase_q != PH_HEADER, byte_count_q >= HDR_LEN_W, "frame phase before header end")

endmodule

// File: rtl/pfp_fifo.sv
// ----------------------------------------------------------------------------
// pfp_fifo
// Short flip-flop queue of parsed entries between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_frame_parser_macros.svh"

module pfp_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pfp_pkg::entry_t wr_data,
	output logic            full,
	input  logic            pop,
	output pfp_pkg::entry_t rd_data,
	output logic            empty
);
	import pfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PFP_ASSERT_IMP(a_fifo_no_overflow, push, !full, "push into full queue")
	`PFP_ASSERT_IMP(a_fifo_no_underflow, pop, !empty, "pop from empty queue")
	`PFP_ASSERT_NXT(a_fifo_push_lands, push && !pop, !empty, "pushed entry lost")

endmodule

// File: rtl/pfp_back.sv
// ----------------------------------------------------------------------------
// pfp_back
// Turns queued entries into result items in an output register; an entry
// with both a frame item and a verdict is played out over two items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_frame_parser_macros.svh"

module pfp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  pfp_pkg::entry_t q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      out_kind,
	output logic [7:0]      data_byte,
	output logic [7:0]      frame_type,
	output logic [7:0]      frame_index,
	output logic            frame_end,
	output logic [7:0]      hdr_flags,
	output logic [63:0]     hdr_session,
	output logic [63:0]     hdr_sequence,
	output logic [7:0]      hdr_frames,
	output logic [2:0]      status,
	output logic            packet_end
);
	import pfp_pkg::*;

	logic        out_valid_q;
	logic        second_q;
	logic        load;
	logic        both;
	logic        emit_frame;
	logic [1:0]  kind_q;
	logic [7:0]  data_q, type_q, index_q, flags_q, frames_q;
	logic        fend_q, pend_q;
	logic [63:0] session_q, sequence_q;
	logic [2:0]  status_q;

	assign load       = !q_empty && (!out_valid_q || !out_stall);
	assign both       = q_head.has_frame && q_head.has_verdict;
	assign emit_frame = q_head.has_frame && !second_q;
	assign q_pop      = load && (!both || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			second_q    <= both && !second_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_frame) begin
				kind_q     <= q_head.frame_kind;
				data_q     <= q_head.data_byte;
				type_q     <= q_head.frame_type;
				index_q    <= q_head.frame_index;
				fend_q     <= q_head.frame_end;
				flags_q    <= '0;
				session_q  <= '0;
				sequence_q <= '0;
				frames_q   <= '0;
				status_q   <= ST_OK;
				pend_q     <= 1'b0;
			end else begin
				kind_q     <= KIND_VERDICT;
				data_q     <= '0;
				type_q     <= '0;
				index_q    <= '0;
				fend_q     <= 1'b0;
				flags_q    <= q_head.hdr_flags;
				session_q  <= q_head.hdr_session;
				sequence_q <= q_head.hdr_sequence;
				frames_q   <= q_head.hdr_frames;
				status_q   <= q_head.status;
				pend_q     <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign data_byte    = data_q;
	assign frame_type   = type_q;
	assign frame_index  = index_q;
	assign frame_end    = fend_q;
	assign hdr_flags    = flags_q;
	assign hdr_session  = session_q;
	assign hdr_sequence = sequence_q;
	assign hdr_frames   = frames_q;
	assign status       = status_q;
	assign packet_end   = pend_q;

	// The verdict half of a split entry must still sit at the queue head.
	`PFP_ASSERT_IMP(a_back_split_head, second_q, !q_empty && q_head.has_frame && q_head.has_verdict, "split entry left queue early")

endmodule

// File: rtl/packet_frame_parser.sv
// A byte's first result item passes through the queue and then the output register on its way out.
// Throughput: one byte per cycle while the queue is not full; a last byte that also ends
// a frame gives two items and holds the output register for an extra item.
// The four-entry queue absorbs such extra items and output stalls before input stalls.
// Reset clears packet state and sets expected_magic to 0 and expected_version to 1.
// ----------------------------------------------------------------------------
// packet_frame_parser
// Byte-serial packet parser: checks the 23-byte header, splits the frame run
// into tagged data items and empty-frame markers, and closes each packet with
// a verdict item carrying the header fields and a status code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_frame_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// Result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  frame_type,
	output logic [7:0]  frame_index,
	output logic        frame_end,
	output logic [7:0]  hdr_flags,
	output logic [63:0] hdr_session,
	output logic [63:0] hdr_sequence,
	output logic [7:0]  hdr_frames,
	output logic [2:0]  status,
	output logic        packet_end
);
	import pfp_pkg::*;

	// Register map: expected_magic at byte address 0, expected_version at 4.
	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	logic [15:0] magic_q;
	logic [7:0]  version_q;
	logic        reg_wr;
	logic        reg_sel;

	entry_t      push_entry;
	entry_t      head_entry;
	logic        q_push, q_pop, q_full, q_empty;

	// The register port never inserts wait states.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= 16'd0;
			version_q <= 8'd1;
		end else if (reg_wr) begin
			unique case (reg_sel)
				REG_MAGIC:   magic_q   <= pwdata[15:0];
				REG_VERSION: version_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MAGIC:   prdata = {16'd0, magic_q};
			REG_VERSION: prdata = {24'd0, version_q};
			default:     prdata = '0;
		endcase
	end

	// Front end: byte-by-byte header and frame state, one queue entry per
	// byte that produces anything.
	pfp_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.expected_magic   (magic_q),
		.expected_version (version_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_data           (push_entry)
	);

	// Decoupling queue, so an output stall does not immediately stop input.
	pfp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (push_entry),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (head_entry),
		.empty   (q_empty)
	);

	// Back end: output register, splits a combined entry into two items.
	pfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (head_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.data_byte    (data_byte),
		.frame_type   (frame_type),
		.frame_index  (frame_index),
		.frame_end    (frame_end),
		.hdr_flags    (hdr_flags),
		.hdr_session  (hdr_session),
		.hdr_sequence (hdr_sequence),
		.hdr_frames   (hdr_frames),
		.status       (status),
		.packet_end   (packet_end)
	);

endmodule
